FILE: src/kfad_pkg.sv
// ----------------------------------------------------------------------------
// kfad_pkg
// Shared types and constants for the Kalman follow / avoid drive block.
// ----------------------------------------------------------------------------
package kfad_pkg;

  // fractional bits of every distance (Q(16-D).D centimetres)
  localparam int unsigned DIST_FRAC_BITS = 8;

  localparam int unsigned DIST_W  = 16;
  localparam int unsigned IR_W    = 12;
  localparam int unsigned BASE_W  = 11;
  localparam int unsigned SPEED_W = 12;
  localparam int unsigned NOISE_W = 16;
  localparam int unsigned COV_W   = 18;
  localparam int unsigned CFG_W   = 16;

  localparam logic [DIST_W-1:0] SIX_DIST  = DIST_W'(6 << DIST_FRAC_BITS);
  localparam logic [DIST_W-1:0] FIVE_DIST = DIST_W'(5 << DIST_FRAC_BITS);

  localparam logic [COV_W-1:0] COV_MAX   = {COV_W{1'b1}};
  localparam logic [COV_W-1:0] COV_RESET = COV_W'(65536);

  localparam logic [BASE_W-1:0] SPEED_CEIL  = BASE_W'(2000);
  localparam logic [BASE_W-1:0] SPEED_FLOOR = BASE_W'(300);
  localparam logic [BASE_W-1:0] TURN_SPEED  = BASE_W'(800);
  localparam logic [6:0]        RAMP_STEP   = 7'd100;

  // restoring divider: quotient of (P << 16) / (P + R) has 17 bits
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_HALT  = 2'd0,
    MODE_TRACK = 2'd1,
    MODE_EVADE = 2'd2,
    MODE_SPARE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_PROC_NOISE  = 3'd0,
    REG_MEAS_NOISE  = 3'd1,
    REG_STOP_DIST   = 3'd2,
    REG_FOLLOW_MAX  = 3'd3,
    REG_AVOID_DIST  = 3'd4,
    REG_BASE_SPEED  = 3'd5,
    REG_IR_TURN     = 3'd6,
    REG_IR_BACK     = 3'd7
  } reg_idx_e;

endpackage

FILE: src/kfad_intf.sv
// ----------------------------------------------------------------------------
// kfad_intf
// Valid/ready channels of the drive block: sensor words in, wheel words out,
// register writes.
// ----------------------------------------------------------------------------
interface kfad_in_if;
  logic                              valid;
  logic                              ready;
  logic [kfad_pkg::DIST_W-1:0]       sonar_range;
  logic [kfad_pkg::IR_W-1:0]         ir_left;
  logic [kfad_pkg::IR_W-1:0]         ir_right;
  logic [1:0]                        drive_mode;

  modport source (output valid, sonar_range, ir_left, ir_right, drive_mode, input ready);
  modport sink   (input valid, sonar_range, ir_left, ir_right, drive_mode, output ready);
endinterface

interface kfad_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [kfad_pkg::SPEED_W-1:0] wheel_left;
  logic signed [kfad_pkg::SPEED_W-1:0] wheel_right;
  logic [kfad_pkg::DIST_W-1:0]         range_est;

  modport source (output valid, wheel_left, wheel_right, range_est, input ready);
  modport sink   (input valid, wheel_left, wheel_right, range_est, output ready);
endinterface

interface kfad_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 index;
  logic [kfad_pkg::CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/kalman_follow_avoid_drive.sv
// ----------------------------------------------------------------------------
// kalman_follow_avoid_drive
// Scalar Kalman distance filter with follow / avoid wheel steering.
// ----------------------------------------------------------------------------
// Use:
//   in_i  : one word per sensor tick (distance, two IR readings, drive mode).
//   out_o : one word per input word (left / right speed, filtered distance).
//   cfg_i : register writes, always ready; write only while the block is idle.
// Each word runs through one sequencer: covariance predict, a restoring
// divider for the gain (one quotient bit a cycle), then three passes through
// one shared 18x18 multiplier (estimate, covariance, speed ramp) and a final
// steering step. The result word is registered as that step ends;
// in_i.ready rises with it, so the next word is taken only after the result
// of the last one is registered. When the output does not stall, the divider
// takes most of each word's time.
// The result sits in an output register, so a new word is taken while it
// waits; if the receiver still stalls when the next result is due, the
// sequencer holds in its last step until the register frees.
// Reset: estimate 0, covariance 1.0, registers to their defaults, no result.
// ----------------------------------------------------------------------------
module kalman_follow_avoid_drive (
  input logic       clk_i,
  input logic       rst_ni,
  kfad_cfg_if.sink  cfg_i,
  kfad_in_if.sink   in_i,
  kfad_out_if.source out_o
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_PRED = 10'b0000000010,
    ST_DIV  = 10'b0000000100,
    ST_GAIN = 10'b0000001000,
    ST_MX   = 10'b0000010000,
    ST_UPX  = 10'b0000100000,
    ST_MP   = 10'b0001000000,
    ST_UPP  = 10'b0010000000,
    ST_MS   = 10'b0100000000,
    ST_OUT  = 10'b1000000000
  } state_e;

  localparam int unsigned DW = kfad_pkg::DIST_W;
  localparam int unsigned CW = kfad_pkg::COV_W;
  localparam int unsigned SW = kfad_pkg::SPEED_W;
  localparam int unsigned FB = kfad_pkg::DIST_FRAC_BITS;

  state_e state_q, state_d;

  // configuration
  logic [kfad_pkg::NOISE_W-1:0] proc_noise_q, meas_noise_q;
  logic [DW-1:0]                stop_dist_q, follow_max_q, avoid_dist_q;
  logic [kfad_pkg::BASE_W-1:0]  base_speed_q;
  logic [kfad_pkg::IR_W-1:0]    ir_turn_q, ir_back_q;

  // filter state
  logic [DW-1:0] est_q;
  logic [CW-1:0] cov_q;

  // latched word
  logic [DW-1:0]             meas_q;
  logic [kfad_pkg::IR_W-1:0] ir_left_q, ir_right_q;
  kfad_pkg::mode_e           mode_q;

  // divider and multiplier
  logic [CW-1:0]                  p1_q;
  logic [CW:0]                    den_q;
  logic [CW+1:0]                  rem_q;
  logic [kfad_pkg::DIV_STEPS-1:0] quo_q;
  logic [kfad_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [15:0]                    gain_q;
  logic                           neg_q;
  logic [CW-1:0]                  mul_a_q, mul_b_q;
  logic [2*CW-1:0]                prod_q;

  // output register
  logic                 ovalid_q;
  logic signed [SW-1:0] lspd_q, rspd_q;
  logic [DW-1:0]        fdist_q;

  // ---- combinational datapath ----
  logic [CW:0]    p_sum;
  logic [CW-1:0]  p1_d;
  logic [CW+1:0]  trial;
  logic           rem_ge;
  logic           diff_neg;
  logic [DW-1:0]  abs_diff;
  logic [15:0]    gain_d;
  logic [DW-1:0]  delta;
  logic [DW-1:0]  est_new;
  logic [DW-1:0]  excess;
  logic [19:0]    off, base20, far_t, near_sum;
  logic [kfad_pkg::BASE_W-1:0] base_eff, follow_spd;
  logic signed [SW-1:0] pos_base, neg_base, turn_pos, turn_neg, follow_s;
  logic signed [SW-1:0] ls_d, rs_d;
  logic           ldet, rdet;
  logic           out_free;

  assign p_sum  = {1'b0, cov_q} + (CW+1)'(proc_noise_q);
  assign p1_d   = p_sum[CW] ? kfad_pkg::COV_MAX : p_sum[CW-1:0];
  assign trial  = rem_q - {1'b0, den_q};
  assign rem_ge = rem_q >= {1'b0, den_q};

  assign diff_neg = meas_q < est_q;
  assign abs_diff = diff_neg ? (est_q - meas_q) : (meas_q - est_q);

  always_comb begin
    if (den_q == '0) begin
      gain_d = '0;
    end else if (quo_q[kfad_pkg::DIV_STEPS-1]) begin
      gain_d = 16'hFFFF;
    end else begin
      gain_d = quo_q[15:0];
    end
  end

  // |delta| <= |meas - est|, so the new estimate stays between the two
  assign delta   = prod_q[31:16];
  assign est_new = neg_q ? (est_q - delta) : (est_q + delta);

  assign excess = (est_q > kfad_pkg::SIX_DIST) ? (est_q - kfad_pkg::SIX_DIST)
                                               : (kfad_pkg::FIVE_DIST - est_q);

  assign base_eff = (base_speed_q > kfad_pkg::SPEED_CEIL) ? kfad_pkg::SPEED_CEIL
                                                          : base_speed_q;
  assign off      = 20'(prod_q[DW+6:FB]);
  assign base20   = 20'(base_eff);
  assign far_t    = base20 + off;
  assign near_sum = off + 20'(kfad_pkg::SPEED_FLOOR);

  always_comb begin
    if (est_q > kfad_pkg::SIX_DIST) begin
      follow_spd = (far_t > 20'(kfad_pkg::SPEED_CEIL)) ? kfad_pkg::SPEED_CEIL
                                                       : far_t[kfad_pkg::BASE_W-1:0];
    end else if (est_q >= kfad_pkg::FIVE_DIST) begin
      follow_spd = base_eff;
    end else if (near_sum > base20) begin
      follow_spd = kfad_pkg::SPEED_FLOOR;
    end else begin
      follow_spd = base_eff - off[kfad_pkg::BASE_W-1:0];
    end
  end

  assign pos_base = signed'({1'b0, base_eff});
  assign neg_base = -pos_base;
  assign turn_pos = signed'({1'b0, kfad_pkg::TURN_SPEED});
  assign turn_neg = -turn_pos;
  assign follow_s = signed'({1'b0, follow_spd});
  assign ldet     = ir_left_q < ir_turn_q;
  assign rdet     = ir_right_q < ir_turn_q;

  always_comb begin
    ls_d = '0;
    rs_d = '0;
    case (mode_q)
      kfad_pkg::MODE_TRACK: begin
        if (est_q <= stop_dist_q) begin
          ls_d = '0;
          rs_d = '0;
        end else if (est_q > follow_max_q) begin
          // search: spin toward a target seen on one side only
          if (ldet && !rdet) begin
            ls_d = turn_neg;
            rs_d = turn_pos;
          end else if (!ldet && rdet) begin
            ls_d = turn_pos;
            rs_d = turn_neg;
          end
        end else begin
          ls_d = follow_s;
          rs_d = follow_s;
        end
      end
      kfad_pkg::MODE_EVADE: begin
        if (est_q < avoid_dist_q || ir_left_q < ir_back_q || ir_right_q < ir_back_q ||
            (ldet && rdet)) begin
          ls_d = neg_base;
          rs_d = neg_base;
        end else if (ldet) begin
          ls_d = pos_base;
          rs_d = neg_base;
        end else if (rdet) begin
          ls_d = neg_base;
          rs_d = pos_base;
        end else begin
          ls_d = pos_base;
          rs_d = pos_base;
        end
      end
      default: begin
        ls_d = '0;
        rs_d = '0;
      end
    endcase
  end

  assign out_free = !ovalid_q || out_o.ready;

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_PRED;
      ST_PRED: state_d = ST_DIV;
      ST_DIV:  if (cnt_q == '0) state_d = ST_GAIN;
      ST_GAIN: state_d = ST_MX;
      ST_MX:   state_d = ST_UPX;
      ST_UPX:  state_d = ST_MP;
      ST_MP:   state_d = ST_UPP;
      ST_UPP:  state_d = ST_MS;
      ST_MS:   state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      est_q    <= '0;
      cov_q    <= kfad_pkg::COV_RESET;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PRED) begin
        cnt_q <= kfad_pkg::DIV_CNT_W'(kfad_pkg::DIV_STEPS - 1);
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (state_q == ST_UPX) est_q <= est_new;
      // P * (1 - K) never exceeds P, so no saturation here
      if (state_q == ST_UPP) cov_q <= prod_q[CW+15:16];
      if (state_q == ST_OUT && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a_q * mul_b_q;
    unique case (state_q)
      ST_IDLE: begin
        meas_q     <= in_i.sonar_range;
        ir_left_q  <= in_i.ir_left;
        ir_right_q <= in_i.ir_right;
        mode_q     <= kfad_pkg::mode_e'(in_i.drive_mode);
      end
      ST_PRED: begin
        p1_q  <= p1_d;
        den_q <= {1'b0, p1_d} + (CW+1)'(meas_noise_q);
        rem_q <= (CW+2)'(p1_d);
        quo_q <= '0;
      end
      ST_DIV: begin
        quo_q <= {quo_q[kfad_pkg::DIV_STEPS-2:0], rem_ge};
        rem_q <= (rem_ge ? trial : rem_q) << 1;
      end
      ST_GAIN: begin
        gain_q  <= gain_d;
        neg_q   <= diff_neg;
        mul_a_q <= CW'(abs_diff);
        mul_b_q <= CW'(gain_d);
      end
      ST_UPX: begin
        mul_a_q <= CW'(17'h10000 - 17'(gain_q));
        mul_b_q <= p1_q;
      end
      ST_UPP: begin
        mul_a_q <= CW'(excess);
        mul_b_q <= CW'(kfad_pkg::RAMP_STEP);
      end
      ST_OUT: begin
        if (out_free) begin
          lspd_q  <= ls_d;
          rspd_q  <= rs_d;
          fdist_q <= est_q;
        end
      end
      default: begin
      end
    endcase
  end

  // ---- register file ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_noise_q <= 16'd6554;
      meas_noise_q <= 16'd6554;
      stop_dist_q  <= 16'd512;
      follow_max_q <= 16'd2560;
      avoid_dist_q <= 16'd1280;
      base_speed_q <= 11'd800;
      ir_turn_q    <= 12'd200;
      ir_back_q    <= 12'd100;
    end else if (cfg_i.valid) begin
      unique case (kfad_pkg::reg_idx_e'(cfg_i.index))
        kfad_pkg::REG_PROC_NOISE: proc_noise_q <= cfg_i.data;
        kfad_pkg::REG_MEAS_NOISE: meas_noise_q <= cfg_i.data;
        kfad_pkg::REG_STOP_DIST:  stop_dist_q  <= cfg_i.data;
        kfad_pkg::REG_FOLLOW_MAX: follow_max_q <= cfg_i.data;
        kfad_pkg::REG_AVOID_DIST: avoid_dist_q <= cfg_i.data;
        kfad_pkg::REG_BASE_SPEED: base_speed_q <= cfg_i.data[kfad_pkg::BASE_W-1:0];
        kfad_pkg::REG_IR_TURN:    ir_turn_q    <= cfg_i.data[kfad_pkg::IR_W-1:0];
        kfad_pkg::REG_IR_BACK:    ir_back_q    <= cfg_i.data[kfad_pkg::IR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);

  assign out_o.valid       = ovalid_q;
  assign out_o.wheel_left  = lspd_q;
  assign out_o.wheel_right = rspd_q;
  assign out_o.range_est   = fdist_q;

endmodule

FILE: src/kfad_checker.sv
// ----------------------------------------------------------------------------
// kfad_checker
// Port-level checks on the drive block, attached by bind.
// ----------------------------------------------------------------------------
module kfad_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [kfad_pkg::SPEED_W-1:0] wheel_left_i,
  input logic signed [kfad_pkg::SPEED_W-1:0] wheel_right_i,
  input logic [kfad_pkg::DIST_W-1:0]         range_est_i
);

  // sequencer is busy straight after taking a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("kfad: ready high in cycle after accept");

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(wheel_left_i) && $stable(wheel_right_i) &&
       $stable(range_est_i)))
    else $error("kfad: stalled result changed");

  // wheel commands stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (wheel_left_i >= -12'sd2000 && wheel_left_i <= 12'sd2000 &&
                     wheel_right_i >= -12'sd2000 && wheel_right_i <= 12'sd2000))
    else $error("kfad: speed out of range");

  // every steering choice drives both wheels equal or mirrored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (wheel_left_i == wheel_right_i || wheel_left_i == -wheel_right_i))
    else $error("kfad: wheel speeds neither equal nor mirrored");

endmodule

bind kalman_follow_avoid_drive kfad_checker u_kfad_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .wheel_left_i  (out_o.wheel_left),
  .wheel_right_i (out_o.wheel_right),
  .range_est_i   (out_o.range_est)
);
